### rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, codes and constants of the RS-485 frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

    localparam int MAX_FRAME_DEF = 256;

    localparam logic [7:0] HEADER_RESET  = 8'hAA;
    localparam logic [7:0] TAIL_RESET    = 8'hBB;
    localparam logic [7:0] MIN_LEN_RESET = 8'd21;
    localparam logic [7:0] CRC_POLY      = 8'h8C;

    localparam int PAYLOAD_BASE = 17;
    localparam int FLEN_BASE    = 20;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t REG_HEADER  = 2'd0;
    localparam cfg_idx_t REG_TAIL    = 2'd1;
    localparam cfg_idx_t REG_MIN_LEN = 2'd2;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_LEN  = 3'd1,
        ST_HDR  = 3'd2,
        ST_TAIL = 3'd3,
        ST_CRC  = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] tail_byte;
        logic [7:0] min_frame_len;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } beat_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] trans_id;
        logic [7:0] frame_length;
    } verdict_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/rfc_ifs.sv
// ----------------------------------------------------------------------------
// rfc_ifs
// Valid/ready channels of the frame checker: received beats, verdicts and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfc_rx_if;
    import rfc_pkg::*;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rfc_verdict_if;
    import rfc_pkg::*;
    logic       valid;
    logic       ready;
    status_t    status;
    logic [7:0] trans_id;
    logic [7:0] frame_length;
    modport source (output valid, output status, output trans_id, output frame_length,
                    input ready);
    modport sink   (input valid, input status, input trans_id, input frame_length,
                    output ready);
endinterface

interface rfc_cfg_if;
    import rfc_pkg::*;
    logic       valid;
    logic       ready;
    cfg_idx_t   index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/rfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfc_cfg_regs
// Configuration registers: header byte, tail byte and minimum frame length.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_cfg_regs (
    input  wire            clk,
    input  wire            rst_n,
    rfc_cfg_if.sink        cfg,
    output rfc_pkg::cfg_t  cfg_q
);
    import rfc_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER:  regs_next.header_byte   = cfg.data;
                REG_TAIL:    regs_next.tail_byte     = cfg.data;
                REG_MIN_LEN: regs_next.min_frame_len = cfg.data;
                default:     regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.header_byte   <= HEADER_RESET;
            regs_reg.tail_byte     <= TAIL_RESET;
            regs_reg.min_frame_len <= MIN_LEN_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

### rtl/rfc_frame_check.sv
// ----------------------------------------------------------------------------
// rfc_frame_check
// Per-frame state: byte count, running CRC-8, header/tail/CRC flags, and the
// verdict formed from them at line idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_frame_check #(
    parameter int MAX_FRAME = rfc_pkg::MAX_FRAME_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               fire,
    input  rfc_pkg::beat_t    beat,
    input  rfc_pkg::cfg_t     cfg_q,
    output rfc_pkg::verdict_t verdict
);
    import rfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int CW    = ((CNT_W > 9) ? CNT_W : 9) + 1;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       tid_reg, tid_next;
    logic             hdr_good_reg, hdr_good_next;
    logic             tail_good_reg, tail_good_next;
    logic             crc_seen_reg, crc_seen_next;
    logic             crc_good_reg, crc_good_next;

    logic [CW-1:0]    p;
    logic [CW-1:0]    t;
    logic             full;
    logic [7:0]       crc_upd;
    logic [8:0]       flen_sum;
    status_t          status;

    assign p        = CW'(cnt_reg);
    assign t        = CW'(PAYLOAD_BASE) + CW'(len_reg);
    assign full     = (cnt_reg >= CNT_W'(MAX_FRAME));
    assign crc_upd  = crc8_update(crc_reg, beat.rx_byte);
    assign flen_sum = 9'(FLEN_BASE) + 9'(len_reg);

    always_comb
    begin
        cnt_next       = cnt_reg;
        crc_next       = crc_reg;
        len_next       = len_reg;
        tid_next       = tid_reg;
        hdr_good_next  = hdr_good_reg;
        tail_good_next = tail_good_reg;
        crc_seen_next  = crc_seen_reg;
        crc_good_next  = crc_good_reg;
        if (fire)
        begin
            if (beat.kind == KIND_IDLE)
            begin
                cnt_next       = '0;
                crc_next       = '0;
                len_next       = '0;
                tid_next       = '0;
                hdr_good_next  = 1'b1;
                tail_good_next = 1'b1;
                crc_seen_next  = 1'b0;
                crc_good_next  = 1'b0;
            end
            else if (!full)
            begin
                if (p < CW'(2) && beat.rx_byte != cfg_q.header_byte)
                begin
                    hdr_good_next = 1'b0;
                end
                if (p == CW'(2))
                begin
                    tid_next = beat.rx_byte;
                end
                if (p == CW'(16))
                begin
                    len_next = beat.rx_byte;
                end
                if (p < CW'(PAYLOAD_BASE))
                begin
                    crc_next = crc_upd;
                end
                else if (p <= t + CW'(1))
                begin
                    if ((p == t || p == t + CW'(1)) && beat.rx_byte != cfg_q.tail_byte)
                    begin
                        tail_good_next = 1'b0;
                    end
                    crc_next = crc_upd;
                end
                else if (p == t + CW'(2))
                begin
                    crc_seen_next = 1'b1;
                    crc_good_next = (beat.rx_byte == crc_reg);
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        if (p < CW'(cfg_q.min_frame_len) || full)
        begin
            status = ST_LEN;
        end
        else if (p < CW'(2) || !hdr_good_reg)
        begin
            status = ST_HDR;
        end
        else if (!tail_good_reg || !crc_seen_reg)
        begin
            status = ST_TAIL;
        end
        else if (!crc_good_reg)
        begin
            status = ST_CRC;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        verdict.status   = status;
        verdict.trans_id = tid_reg;
        if (status != ST_OK)
        begin
            verdict.frame_length = 8'd0;
        end
        else if (flen_sum[8])
        begin
            verdict.frame_length = 8'hFF;
        end
        else
        begin
            verdict.frame_length = flen_sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            crc_reg       <= '0;
            len_reg       <= '0;
            tid_reg       <= '0;
            hdr_good_reg  <= 1'b1;
            tail_good_reg <= 1'b1;
            crc_seen_reg  <= 1'b0;
            crc_good_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            len_reg       <= len_next;
            tid_reg       <= tid_next;
            hdr_good_reg  <= hdr_good_next;
            tail_good_reg <= tail_good_next;
            crc_seen_reg  <= crc_seen_next;
            crc_good_reg  <= crc_good_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_FRAME))
        else $error("byte count past frame buffer");

    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && beat.kind == KIND_IDLE |=> cnt_reg == '0 && !crc_seen_reg)
        else $error("frame state not cleared after idle");

    a_crc_pos: assert property (@(posedge clk) disable iff (!rst_n)
        crc_seen_reg |-> p >= CW'(FLEN_BASE))
        else $error("crc byte seen too early");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.status == ST_OK |-> verdict.frame_length >= 8'(FLEN_BASE))
        else $error("ok verdict with short frame length");
`endif

endmodule

`default_nettype wire

### rtl/rfc_out_stage.sv
// ----------------------------------------------------------------------------
// rfc_out_stage
// Result register: holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_out_stage (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  rfc_pkg::verdict_t verdict,
    output logic              space,
    rfc_verdict_if.source     out
);
    import rfc_pkg::*;

    logic     valid_reg, valid_next;
    verdict_t data_reg;

    assign space            = !valid_reg || out.ready;
    assign out.valid        = valid_reg;
    assign out.status       = data_reg.status;
    assign out.trans_id     = data_reg.trans_id;
    assign out.frame_length = data_reg.frame_length;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= verdict;
        end
    end

endmodule

`default_nettype wire

### rtl/rs485_frame_checker.sv
// ----------------------------------------------------------------------------
// rs485_frame_checker
// Checks RS-485 frames byte by byte (header, length, tail, CRC-8) and gives
// one verdict per line-idle beat.
// ----------------------------------------------------------------------------
//  channel  dir  payload                            beats
//  rx       in   kind, rx_byte                      one per received byte or idle
//  verdict  out  status, trans_id, frame_length     one per idle beat
//  cfg      in   index, data                        register write, always ready
//
//  One beat per cycle while the input is not stalled; as a beat leaves the
//  input register it updates the frame state and CRC-8, and an idle beat
//  loads its verdict into the result register, which presents it.
//  A data beat in the input register always advances; the input stalls only
//  while an idle beat there waits on a verdict that is not being taken.
//  Reset loads header 0xAA, tail 0xBB, minimum length 21 and clears the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rs485_frame_checker #(
    parameter int MAX_FRAME = rfc_pkg::MAX_FRAME_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    rfc_rx_if.sink         rx,
    rfc_verdict_if.source  verdict,
    rfc_cfg_if.sink        cfg
);
    import rfc_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    beat_t    s1_beat_reg;
    logic     s1_fire;
    logic     accept;
    logic     out_space;
    cfg_t     cfg_q;
    verdict_t verdict_d;

    assign s1_fire  = s1_valid_reg && (s1_beat_reg.kind == KIND_DATA || out_space);
    assign rx.ready = !s1_valid_reg || s1_fire;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg.kind    <= rx.kind;
            s1_beat_reg.rx_byte <= rx.rx_byte;
        end
    end

    rfc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    rfc_frame_check #(
        .MAX_FRAME (MAX_FRAME)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .beat    (s1_beat_reg),
        .cfg_q   (cfg_q),
        .verdict (verdict_d)
    );

    rfc_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s1_fire && s1_beat_reg.kind == KIND_IDLE),
        .verdict (verdict_d),
        .space   (out_space),
        .out     (verdict)
    );

endmodule

`default_nettype wire

### sim/tb_rs485_frame_checker.sv
// ----------------------------------------------------------------------------
// tb_rs485_frame_checker
// Self-checking bench for the RS-485 frame checker. A scoreboard class tracks
// the frame state and running CRC-8 of every accepted beat and queues the
// verdict each idle beat should produce. Directed frames cover empty, short,
// minimum, overlong, truncated and maximum-length frames and every status
// code. Random phases follow, each with its own register setting and its own
// amount of sender gaps and receiver stalls. One phase holds off the verdict
// channel for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_rs485_frame_checker;
    import rfc_pkg::*;

    localparam cfg_idx_t REG_UNUSED = 2'd3;
    localparam int       LONG_HOLD  = 400;

    typedef enum {
        FR_GOOD,
        FR_BAD_HDR,
        FR_BAD_TAIL,
        FR_BAD_CRC,
        FR_TRUNC,
        FR_TRAIL,
        FR_NOISE,
        FR_OVERLONG
    } frame_kind_e;

    class frame_scoreboard;
        logic [7:0]  hdr_val;
        logic [7:0]  tail_val;
        logic [7:0]  min_len;
        int          count;
        logic [7:0]  acc;
        logic [7:0]  pay_len;
        logic [7:0]  tid;
        bit          hdr_ok;
        bit          tail_ok;
        bit          crc_got;
        bit          crc_match;
        verdict_t    verdicts_due[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            hdr_val  = HEADER_RESET;
            tail_val = TAIL_RESET;
            min_len  = MIN_LEN_RESET;
            errors   = 0;
            checked  = 0;
            clear_frame();
        endfunction

        static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] d);
            logic [7:0] r;
            r = crc;
            for (int i = 0; i < 8; i++)
            begin
                if (r[0] ^ d[i])
                begin
                    r = {1'b0, r[7:1]} ^ CRC_POLY;
                end
                else
                begin
                    r = {1'b0, r[7:1]};
                end
            end
            return r;
        endfunction

        function void clear_frame();
            count     = 0;
            acc       = 8'h00;
            pay_len   = 8'h00;
            tid       = 8'h00;
            hdr_ok    = 1'b1;
            tail_ok   = 1'b1;
            crc_got   = 1'b0;
            crc_match = 1'b0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [7:0] v);
            case (idx)
                REG_HEADER:  hdr_val  = v;
                REG_TAIL:    tail_val = v;
                REG_MIN_LEN: min_len  = v;
                default:     ;
            endcase
        endfunction

        function void note_beat(logic k, logic [7:0] b);
            verdict_t v;
            int       tail_pos;
            int       flen;
            if (k == KIND_DATA)
            begin
                tail_pos = PAYLOAD_BASE + int'(pay_len);
                if (count >= MAX_FRAME_DEF)
                begin
                    return;
                end
                if (count < 2 && b != hdr_val)
                begin
                    hdr_ok = 1'b0;
                end
                if (count == 2)
                begin
                    tid = b;
                end
                if (count == 16)
                begin
                    pay_len = b;
                end
                if (count < PAYLOAD_BASE)
                begin
                    acc = crc8_step(acc, b);
                end
                else if (count <= tail_pos + 1)
                begin
                    if ((count == tail_pos || count == tail_pos + 1) && b != tail_val)
                    begin
                        tail_ok = 1'b0;
                    end
                    acc = crc8_step(acc, b);
                end
                else if (count == tail_pos + 2)
                begin
                    crc_got   = 1'b1;
                    crc_match = (b == acc);
                end
                count++;
                return;
            end
            if (count < int'(min_len) || count >= MAX_FRAME_DEF)
            begin
                v.status = ST_LEN;
            end
            else if (count < 2 || !hdr_ok)
            begin
                v.status = ST_HDR;
            end
            else if (!tail_ok || !crc_got)
            begin
                v.status = ST_TAIL;
            end
            else if (!crc_match)
            begin
                v.status = ST_CRC;
            end
            else
            begin
                v.status = ST_OK;
            end
            flen = 0;
            if (v.status == ST_OK)
            begin
                flen = FLEN_BASE + int'(pay_len);
                if (flen > 255)
                begin
                    flen = 255;
                end
            end
            v.trans_id     = tid;
            v.frame_length = 8'(flen);
            verdicts_due.push_back(v);
            clear_frame();
        endfunction

        function void check_verdict(status_t s, logic [7:0] id, logic [7:0] fl);
            verdict_t e;
            if (verdicts_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected verdict: status %0d trans_id %0d frame_length %0d",
                         $time, s, id, fl);
                return;
            end
            e = verdicts_due.pop_front();
            checked++;
            if (s !== e.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, s);
            end
            if (id !== e.trans_id)
            begin
                errors++;
                $display("%0t: trans_id expected %0d actual %0d", $time, e.trans_id, id);
            end
            if (fl !== e.frame_length)
            begin
                errors++;
                $display("%0t: frame_length expected %0d actual %0d",
                         $time, e.frame_length, fl);
            end
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rfc_rx_if      rx_ch ();
    rfc_verdict_if vd_ch ();
    rfc_cfg_if     cfg_ch ();

    rs485_frame_checker u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .verdict (vd_ch),
        .cfg     (cfg_ch)
    );

    frame_scoreboard sb;
    logic [7:0]      fbytes[$];
    logic [7:0]      cur_hdr     = HEADER_RESET;
    logic [7:0]      cur_tail    = TAIL_RESET;
    int unsigned     tx_gap_pct  = 0;
    int unsigned     rx_stall_pct = 0;
    int unsigned     beats_sent  = 0;
    bit              calm        = 1'b0;
    bit              hold_req    = 1'b0;
    bit              holding     = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                sb.note_beat(rx_ch.kind, rx_ch.rx_byte);
            end
            if (vd_ch.valid && vd_ch.ready)
            begin
                sb.check_verdict(vd_ch.status, vd_ch.trans_id, vd_ch.frame_length);
            end
        end
    end

    // verdict receiver: random stall bursts plus one long hold on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        vd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                holding   = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                vd_ch.ready <= 1'b0;
            end
            else
            begin
                holding = 1'b0;
                if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct)
                begin
                    hold_left = $urandom_range(0, 12);
                    vd_ch.ready <= 1'b0;
                end
                else
                begin
                    vd_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_beat(input logic k, input logic [7:0] b);
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.kind    <= k;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        beats_sent++;
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_config(input logic [7:0] h, input logic [7:0] t, input logic [7:0] m);
        put_reg(REG_HEADER, h);
        put_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        put_reg(REG_TAIL, t);
        put_reg(REG_MIN_LEN, m);
        cfg_ch.valid <= 1'b0;
        cur_hdr  = h;
        cur_tail = t;
    endtask

    task automatic drain();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic build_good(input int n);
        logic [7:0] crc;
        crc = 8'h00;
        fbytes.delete();
        fbytes.push_back(cur_hdr);
        fbytes.push_back(cur_hdr);
        repeat (14) fbytes.push_back(8'($urandom_range(0, 255)));
        fbytes.push_back(8'(n));
        repeat (n) fbytes.push_back(8'($urandom_range(0, 255)));
        fbytes.push_back(cur_tail);
        fbytes.push_back(cur_tail);
        foreach (fbytes[i])
        begin
            crc = frame_scoreboard::crc8_step(crc, fbytes[i]);
        end
        fbytes.push_back(crc);
    endtask

    // n is the payload length, or the byte count for noise and overlong frames
    task automatic send_frame(input frame_kind_e fk, input int n);
        int idx;
        int cut;
        case (fk)
            FR_GOOD:
            begin
                build_good(n);
            end
            FR_BAD_HDR:
            begin
                build_good(n);
                idx = $urandom_range(0, 1);
                fbytes[idx] = fbytes[idx] ^ 8'($urandom_range(1, 255));
            end
            FR_BAD_TAIL:
            begin
                build_good(n);
                idx = PAYLOAD_BASE + n + $urandom_range(0, 1);
                fbytes[idx] = fbytes[idx] ^ 8'($urandom_range(1, 255));
            end
            FR_BAD_CRC:
            begin
                build_good(n);
                idx = PAYLOAD_BASE + n + 2;
                fbytes[idx] = fbytes[idx] ^ 8'($urandom_range(1, 255));
            end
            FR_TRUNC:
            begin
                build_good(n);
                cut = $urandom_range(0, PAYLOAD_BASE + n + 2);
                while (fbytes.size() > cut)
                begin
                    void'(fbytes.pop_back());
                end
            end
            FR_TRAIL:
            begin
                build_good(n);
                repeat ($urandom_range(1, 4)) fbytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                fbytes.delete();
                repeat (n) fbytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        foreach (fbytes[j])
        begin
            send_beat(KIND_DATA, fbytes[j]);
        end
        send_beat(KIND_IDLE, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_payload();
        int r;
        r = $urandom_range(1, 100);
        if (r <= 80)
        begin
            return $urandom_range(0, 8);
        end
        if (r <= 96)
        begin
            return $urandom_range(9, 60);
        end
        return $urandom_range(61, 235);
    endfunction

    task automatic send_random_frame();
        int r;
        r = $urandom_range(1, 100);
        if (r <= 35)
        begin
            send_frame(FR_GOOD, pick_payload());
        end
        else if (r <= 43)
        begin
            send_frame(FR_BAD_HDR, pick_payload());
        end
        else if (r <= 53)
        begin
            send_frame(FR_BAD_TAIL, pick_payload());
        end
        else if (r <= 65)
        begin
            send_frame(FR_BAD_CRC, pick_payload());
        end
        else if (r <= 77)
        begin
            send_frame(FR_TRUNC, pick_payload());
        end
        else if (r <= 87)
        begin
            send_frame(FR_TRAIL, pick_payload());
        end
        else if (r <= 98)
        begin
            send_frame(FR_NOISE, $urandom_range(0, 30));
        end
        else
        begin
            send_frame(FR_OVERLONG, $urandom_range(256, 262));
        end
    endtask

    function automatic logic [7:0] pick_marker();
        int r;
        r = $urandom_range(1, 4);
        if (r == 1)
        begin
            return 8'h00;
        end
        if (r == 2)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_pct();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return 10;
        end
        return 30;
    endfunction

    initial
    begin
        int          phase_no;
        int unsigned phase_end;
        logic [7:0]  min_pick;
        sb = new();
        rx_ch.valid    <= 1'b0;
        rx_ch.kind     <= KIND_DATA;
        rx_ch.rx_byte  <= 8'h00;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_HEADER;
        cfg_ch.data    <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_frame(FR_NOISE, 0);
        send_frame(FR_GOOD, 0);
        send_frame(FR_GOOD, 1);
        send_frame(FR_BAD_HDR, 3);
        send_frame(FR_BAD_TAIL, 2);
        send_frame(FR_BAD_CRC, 4);
        send_frame(FR_TRUNC, 2);
        send_frame(FR_TRAIL, 1);
        send_frame(FR_OVERLONG, 260);
        drain();

        set_config(8'h00, 8'hFF, 8'd0);
        send_frame(FR_NOISE, 0);
        send_frame(FR_NOISE, 1);
        send_frame(FR_GOOD, 0);
        send_frame(FR_TRUNC, 0);
        drain();

        set_config(8'hFF, 8'h00, 8'd255);
        send_frame(FR_GOOD, 235);
        drain();

        phase_no   = 0;
        while (beats_sent < 950 || !calm)
        begin
            if (beats_sent >= 850)
            begin
                calm = 1'b1;
            end
            min_pick = ($urandom_range(1, 5) == 1) ? 8'd0 : 8'($urandom_range(1, 25));
            set_config(pick_marker(), pick_marker(), min_pick);
            tx_gap_pct   = calm ? 0 : pick_pct();
            rx_stall_pct = calm ? 0 : pick_pct();
            if (phase_no == 0)
            begin
                hold_req = 1'b1;
                do @(posedge clk); while (!holding);
                repeat (30) send_frame(FR_NOISE, $urandom_range(0, 3));
            end
            phase_end = beats_sent + 60;
            while (beats_sent < phase_end)
            begin
                send_random_frame();
            end
            drain();
            phase_no++;
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
